/* hdl/egbr_pkg.sv */
package egbr_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 4096;

  localparam int OP_W      = 4;
  localparam int BITS_W    = 6;
  localparam int VALUE_W   = 33;
  localparam int ERR_W     = 3;
  localparam int POS_W     = 16;
  localparam int CNT_W     = 13;
  localparam int MAX_ZEROS = 30;
  localparam int MAX_BITS  = 32;
  localparam int WIN_W     = 40;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 4'd0,
    OP_APPEND    = 4'd1,
    OP_REWIND    = 4'd2,
    OP_READ_U    = 4'd3,
    OP_READ_S    = 4'd4,
    OP_PEEK      = 4'd5,
    OP_READ_BYTE = 4'd6,
    OP_PEEK_BYTE = 4'd7,
    OP_UE        = 4'd8,
    OP_SE        = 4'd9,
    OP_ALIGN     = 4'd10
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 3'd0,
    ERR_NO_DATA   = 3'd1,
    ERR_BAD_COUNT = 3'd2,
    ERR_UNALIGNED = 3'd3,
    ERR_ZEROS     = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_P_RD,
    ST_P_DAT,
    ST_SUF,
    ST_G_RD,
    ST_G_DAT,
    ST_G_FIN,
    ST_CODE,
    ST_SIGN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ERR_W-1:0]   err;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   fill;
  } egbr_result_t;

endpackage

/* hdl/egbr_engine.sv */
module egbr_engine import egbr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [7:0]        data_byte_i,
  input  logic [BITS_W-1:0] bit_count_i,
  output logic              res_valid_o,
  output egbr_result_t      res_o,
  input  logic              res_take_i
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);
  localparam int PW = FW + 3;
  localparam logic [FW-1:0] FillMax = FW'(BUFFER_BYTES);

  function automatic logic [3:0] clz8(input logic [7:0] b);
    logic [3:0] r;
    logic       hit;
    r   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && b[i]) begin
        r   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [OP_W-1:0]    op_q, op_d;
  logic [7:0]         data_q, data_d;
  logic [BITS_W-1:0]  n_q, n_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [4:0]         zeros_q, zeros_d;
  logic [WIN_W-1:0]   win_q, win_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [2:0]         nbytes_q, nbytes_d;
  logic [2:0]         off_q, off_d;
  logic [BITS_W-1:0]  gn_q, gn_d;
  logic [31:0]        raw_q, raw_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic [AW-1:0]      addr_q, addr_d;

  logic [7:0] mem_q [BUFFER_BYTES];
  logic [7:0] rdata_q;
  logic       mem_we;
  logic       mem_re;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[fill_q[AW-1:0]] <= data_q;
    end
    if (mem_re) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // status of the current position
  logic [PW-1:0]     total;
  logic              fit_n, fit_byte, fit_z, pos_at_end, aligned, bad_n;
  assign total      = {fill_q, 3'b000};
  assign fit_n      = ((PW+1)'(pos_q) + (PW+1)'(n_q)) <= (PW+1)'(total);
  assign fit_byte   = ((PW+1)'(pos_q) + (PW+1)'(8)) <= (PW+1)'(total);
  assign fit_z      = ((PW+1)'(pos_q) + (PW+1)'(zeros_q)) <= (PW+1)'(total);
  assign pos_at_end = pos_q >= total;
  assign aligned    = pos_q[2:0] == 3'd0;
  assign bad_n      = (n_q == '0) || (n_q > BITS_W'(MAX_BITS));

  // leading zero scan of one byte
  logic [7:0]    rem;
  logic [3:0]    lz, lzc, avail;
  logic [4:0]    need;
  logic          hit_limit, found;
  logic [PW-1:0] pre_pos_limit, pre_pos_one, pre_pos_all;
  assign rem           = rdata_q << pos_q[2:0];
  assign lz            = clz8(rem);
  assign avail         = 4'd8 - {1'b0, pos_q[2:0]};
  assign lzc           = (lz > avail) ? avail : lz;
  assign need          = 5'(MAX_ZEROS) - zeros_q;
  assign hit_limit     = 5'(lzc) >= need;
  assign found         = lzc < avail;
  assign pre_pos_limit = pos_q + PW'(need);
  assign pre_pos_one   = pos_q + PW'(lzc) + PW'(1);
  assign pre_pos_all   = pos_q + PW'(avail);

  // gather setup
  logic              byte_op;
  logic [BITS_W-1:0] gset_n;
  logic [6:0]        gset_sum;
  assign byte_op  = (op_q == OP_READ_BYTE) || (op_q == OP_PEEK_BYTE);
  assign gset_n   = (state_q == ST_SUF) ? BITS_W'(zeros_q) :
                    (byte_op ? BITS_W'(8) : n_q);
  assign gset_sum = 7'(pos_q[2:0]) + 7'(gset_n) + 7'd7;

  // field extraction from the byte window
  logic [5:0]       gshift;
  logic [WIN_W-1:0] raw_win;
  assign gshift  = {nbytes_q, 3'b000} - 6'(off_q) - gn_q;
  assign raw_win = (win_q >> gshift) & ((WIN_W'(1) << gn_q) - WIN_W'(1));

  logic [31:0]        code;
  logic [VALUE_W-1:0] smask;
  assign code  = (32'd1 << zeros_q) - 32'd1 + raw_q;
  assign smask = (VALUE_W'(1) << n_q) - VALUE_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_q)
          OP_READ_U, OP_READ_S, OP_PEEK: begin
            state_d = (!bad_n && fit_n) ? ST_G_RD : ST_FIN;
          end
          OP_READ_BYTE, OP_PEEK_BYTE: begin
            state_d = (aligned && fit_byte) ? ST_G_RD : ST_FIN;
          end
          OP_UE, OP_SE: begin
            state_d = pos_at_end ? ST_FIN : ST_P_RD;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_P_RD: state_d = ST_P_DAT;
      ST_P_DAT: begin
        if (hit_limit) begin
          state_d = ST_FIN;
        end else if (found) begin
          state_d = ST_SUF;
        end else if (pre_pos_all >= total) begin
          state_d = ST_FIN;
        end
      end
      ST_SUF: begin
        if (zeros_q == '0) begin
          state_d = ST_CODE;
        end else if (!fit_z) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_G_RD;
        end
      end
      ST_G_RD:  state_d = ST_G_DAT;
      ST_G_DAT: state_d = (cnt_q > 3'd1) ? ST_G_DAT : ST_G_FIN;
      ST_G_FIN: state_d = ST_CODE;
      ST_CODE:  state_d = (op_q == OP_SE) ? ST_SIGN : ST_FIN;
      ST_SIGN:  state_d = ST_FIN;
      ST_FIN: begin
        if (res_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d     = op_q;
    data_d   = data_q;
    n_d      = n_q;
    pos_d    = pos_q;
    fill_d   = fill_q;
    zeros_d  = zeros_q;
    win_d    = win_q;
    cnt_d    = cnt_q;
    nbytes_d = nbytes_q;
    off_d    = off_q;
    gn_d     = gn_q;
    raw_d    = raw_q;
    value_d  = value_q;
    err_d    = err_q;
    addr_d   = addr_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = operation_i;
          data_d = data_byte_i;
          n_d    = bit_count_i;
        end
      end
      ST_EXEC: begin
        value_d  = '0;
        err_d    = ERR_OK;
        zeros_d  = '0;
        addr_d   = pos_q[AW+2:3];
        off_d    = pos_q[2:0];
        gn_d     = gset_n;
        nbytes_d = gset_sum[5:3];
        cnt_d    = gset_sum[5:3];
        case (op_q)
          OP_CLEAR: begin
            fill_d = '0;
            pos_d  = '0;
          end
          OP_APPEND: begin
            if (fill_q < FillMax) begin
              mem_we = 1'b1;
              fill_d = fill_q + FW'(1);
            end
          end
          OP_REWIND: pos_d = '0;
          OP_READ_U, OP_READ_S, OP_PEEK: begin
            if (bad_n) begin
              err_d = ERR_BAD_COUNT;
            end else if (!fit_n) begin
              err_d = ERR_NO_DATA;
            end else if (op_q != OP_PEEK) begin
              pos_d = pos_q + PW'(n_q);
            end
          end
          OP_READ_BYTE, OP_PEEK_BYTE: begin
            if (!aligned) begin
              err_d = ERR_UNALIGNED;
            end else if (!fit_byte) begin
              err_d = ERR_NO_DATA;
            end else if (op_q == OP_READ_BYTE) begin
              pos_d = pos_q + PW'(8);
            end
          end
          OP_UE, OP_SE: begin
            if (pos_at_end) err_d = ERR_NO_DATA;
          end
          OP_ALIGN: begin
            if (!aligned) pos_d = (pos_q | PW'(7)) + PW'(1);
          end
          default: ;
        endcase
      end
      ST_P_RD: begin
        mem_re = 1'b1;
        addr_d = addr_q + AW'(1);
      end
      ST_P_DAT: begin
        if (hit_limit) begin
          pos_d   = pre_pos_limit;
          zeros_d = 5'(MAX_ZEROS);
          err_d   = (pre_pos_limit >= total) ? ERR_NO_DATA : ERR_ZEROS;
        end else if (found) begin
          pos_d   = pre_pos_one;
          zeros_d = zeros_q + 5'(lzc);
        end else begin
          pos_d   = pre_pos_all;
          zeros_d = zeros_q + 5'(avail);
          if (pre_pos_all >= total) begin
            err_d = ERR_NO_DATA;
          end else begin
            mem_re = 1'b1;
            addr_d = addr_q + AW'(1);
          end
        end
      end
      ST_SUF: begin
        addr_d   = pos_q[AW+2:3];
        off_d    = pos_q[2:0];
        gn_d     = gset_n;
        nbytes_d = gset_sum[5:3];
        cnt_d    = gset_sum[5:3];
        if (zeros_q == '0) begin
          raw_d = '0;
        end else if (!fit_z) begin
          err_d = ERR_NO_DATA;
        end else begin
          pos_d = pos_q + PW'(zeros_q);
        end
      end
      ST_G_RD: begin
        mem_re = 1'b1;
        addr_d = addr_q + AW'(1);
      end
      ST_G_DAT: begin
        win_d = {win_q[WIN_W-9:0], rdata_q};
        cnt_d = cnt_q - 3'd1;
        if (cnt_q > 3'd1) begin
          mem_re = 1'b1;
          addr_d = addr_q + AW'(1);
        end
      end
      ST_G_FIN: raw_d = raw_win[31:0];
      ST_CODE: begin
        case (op_q)
          OP_READ_S: begin
            if (raw_q[n_q[4:0] - 5'd1]) begin
              value_d = {1'b0, raw_q} | ~smask;
            end else begin
              value_d = {1'b0, raw_q};
            end
          end
          OP_UE: value_d = {1'b0, code};
          OP_SE: raw_d = code;
          default: value_d = {1'b0, raw_q};
        endcase
      end
      ST_SIGN: begin
        if (raw_q[0]) begin
          value_d = ({1'b0, raw_q} + VALUE_W'(1)) >> 1;
        end else begin
          value_d = VALUE_W'(0) - {2'b00, raw_q[31:1]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    data_q   <= data_d;
    n_q      <= n_d;
    zeros_q  <= zeros_d;
    win_q    <= win_d;
    cnt_q    <= cnt_d;
    nbytes_q <= nbytes_d;
    off_q    <= off_d;
    gn_q     <= gn_d;
    raw_q    <= raw_d;
    value_q  <= value_d;
    err_q    <= err_d;
    addr_q   <= addr_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign res_valid_o = state_q == ST_FIN;
  assign res_o.value = value_q;
  assign res_o.err   = err_q;
  assign res_o.pos   = POS_W'(pos_q);
  assign res_o.fill  = CNT_W'(fill_q);

endmodule

/* hdl/egbr_out_stage.sv */
module egbr_out_stage import egbr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      res_valid_i,
  input  egbr_result_t              res_i,
  output logic                      res_take_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic [ERR_W-1:0]          error_code_o,
  output logic [POS_W-1:0]          position_bits_o,
  output logic                      is_aligned_o,
  output logic                      bits_left_o,
  output logic [CNT_W-1:0]          stored_bytes_o,
  output logic [CNT_W-1:0]          whole_bytes_left_o
);

  logic               valid_q, valid_d;
  logic [VALUE_W-1:0] value_q;
  logic [ERR_W-1:0]   err_q;
  logic [POS_W-1:0]   pos_q;
  logic               aligned_q, left_q;
  logic [CNT_W-1:0]   fill_q, whole_q;

  logic             load;
  logic [POS_W:0]   pos_round;
  logic [CNT_W:0]   used;
  logic [CNT_W-1:0] whole;

  assign res_take_o = !valid_q || !out_stall_i;
  assign load       = res_valid_i && res_take_o;
  assign pos_round  = {1'b0, res_i.pos} + (POS_W+1)'(7);
  assign used       = pos_round[POS_W:3];
  assign whole      = ({1'b0, res_i.fill} >= used) ?
                      CNT_W'({1'b0, res_i.fill} - used) : '0;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q   <= res_i.value;
      err_q     <= res_i.err;
      pos_q     <= res_i.pos;
      aligned_q <= res_i.pos[2:0] == 3'd0;
      left_q    <= res_i.pos < {res_i.fill, 3'b000};
      fill_q    <= res_i.fill;
      whole_q   <= whole;
    end
  end

  assign out_valid_o        = valid_q;
  assign value_o            = $signed(value_q);
  assign error_code_o       = err_q;
  assign position_bits_o    = pos_q;
  assign is_aligned_o       = aligned_q;
  assign bits_left_o        = left_q;
  assign stored_bytes_o     = fill_q;
  assign whole_bytes_left_o = whole_q;

endmodule

/* hdl/exp_golomb_bitstream_reader.sv */
// the byte store port fetches one byte per cycle
// one transaction at a time: the next is taken once the engine is idle again after its result
// enters the output register, which also holds while out_stall_i is high
// reset clears the fill count, the read position and the handshake state;
// the byte store keeps its contents and needs no clearing pass
module exp_golomb_bitstream_reader import egbr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OP_W-1:0]           operation_i,
  input  logic [7:0]                data_byte_i,
  input  logic [BITS_W-1:0]         bit_count_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic [ERR_W-1:0]          error_code_o,
  output logic [POS_W-1:0]          position_bits_o,
  output logic                      is_aligned_o,
  output logic                      bits_left_o,
  output logic [CNT_W-1:0]          stored_bytes_o,
  output logic [CNT_W-1:0]          whole_bytes_left_o
);

  logic         res_valid;
  logic         res_take;
  egbr_result_t res;

  egbr_engine #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .bit_count_i (bit_count_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  egbr_out_stage u_out_stage (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .res_valid_i        (res_valid),
    .res_i              (res),
    .res_take_o         (res_take),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .value_o            (value_o),
    .error_code_o       (error_code_o),
    .position_bits_o    (position_bits_o),
    .is_aligned_o       (is_aligned_o),
    .bits_left_o        (bits_left_o),
    .stored_bytes_o     (stored_bytes_o),
    .whole_bytes_left_o (whole_bytes_left_o)
  );

endmodule
